### rtl/dotq_pkg.sv
// Package for the deadline ordered timer queue.
// Sizes, result status codes and the storage operation struct.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package dotq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int TIME_BITS   = 32;
    localparam int TAG_W       = 8;
    localparam int STATUS_W    = 2;
    localparam int OCC_W       = 5;
    localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic [STATUS_W-1:0] ST_ADDED    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_REJ_PAST = 2'd1;
    localparam logic [STATUS_W-1:0] ST_REJ_FULL = 2'd2;
    localparam logic [STATUS_W-1:0] ST_DISPATCH = 2'd3;

    localparam logic KIND_ADD  = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    // One storage operation per cycle: insert at pos, or pop the front.
    // pos also selects the entry shown on the indexed read port.
    typedef struct packed {
        logic                 ins;
        logic                 pop;
        logic [IDX_W-1:0]     pos;
        logic [TAG_W-1:0]     tag;
        logic [TIME_BITS-1:0] due;
    } dotq_op_t;

endpackage

`default_nettype wire

### rtl/dotq_store.sv
// Sorted entry storage: due times and tags, insert with shift-up, pop with shift-down.
// Depends on dotq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dotq_store (
    input  wire                           aclk,
    input  wire dotq_pkg::dotq_op_t       op,
    output logic [dotq_pkg::TIME_BITS-1:0] rd_due,
    output logic [dotq_pkg::TIME_BITS-1:0] front_due,
    output logic [dotq_pkg::TAG_W-1:0]     front_tag
);
    import dotq_pkg::*;

    logic [TIME_BITS-1:0] due_reg [QUEUE_DEPTH];
    logic [TAG_W-1:0]     tag_reg [QUEUE_DEPTH];

    assign rd_due    = due_reg[op.pos];
    assign front_due = due_reg[0];
    assign front_tag = tag_reg[0];

    always_ff @(posedge aclk) begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if (op.ins) begin
                if (IDX_W'(i) == op.pos) begin
                    due_reg[i] <= op.due;
                    tag_reg[i] <= op.tag;
                end else if (i > 0 && IDX_W'(i) > op.pos) begin
                    due_reg[i] <= due_reg[(i > 0) ? i - 1 : 0];
                    tag_reg[i] <= tag_reg[(i > 0) ? i - 1 : 0];
                end
            end else if (op.pop && i < QUEUE_DEPTH - 1) begin
                due_reg[i] <= due_reg[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
                tag_reg[i] <= tag_reg[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
            end
        end
    end

endmodule

`default_nettype wire

### rtl/deadline_ordered_timer_queue_top.sv
// Deadline ordered timer queue: sequencer with one shared time comparator.
// Add: accept, a check step, one search step per held entry whose due time is not
// later, then an insert step; a rejected add ends at the check step. Tick: accept,
// then one pop per dispatched entry plus a closing compare. Results wait for a free output.
// One item at a time; s_ready is high only between items, and a waiting result does not
// hold it low. Sync reset (aresetn low) empties the queue; entry storage is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module deadline_ordered_timer_queue_top (
    input  wire                                 aclk,
    input  wire                                 aresetn,
    input  wire                                 s_valid,
    output logic                                s_ready,
    input  wire                                 s_kind,
    input  wire  [dotq_pkg::TAG_W-1:0]          s_task_tag,
    input  wire  [dotq_pkg::TIME_BITS-1:0]      s_due_time,
    input  wire  [dotq_pkg::TIME_BITS-1:0]      s_current_time,
    output logic                                m_valid,
    input  wire                                 m_ready,
    output logic [dotq_pkg::STATUS_W-1:0]       m_status,
    output logic [dotq_pkg::TAG_W-1:0]          m_out_tag,
    output logic [dotq_pkg::TIME_BITS-1:0]      m_out_time,
    output logic [dotq_pkg::OCC_W-1:0]          m_occupancy,
    output logic                                m_last
);
    import dotq_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_SEARCH,
        S_TICK
    } state_t;

    state_t               state_reg, state_next;
    logic [TAG_W-1:0]     tag_reg, tag_next;
    logic [TIME_BITS-1:0] due_reg, due_next;
    logic [TIME_BITS-1:0] now_reg, now_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic                 pend_valid_reg, pend_valid_next;
    logic [TAG_W-1:0]     pend_tag_reg, pend_tag_next;
    logic [TIME_BITS-1:0] pend_due_reg, pend_due_next;
    logic [CNT_W-1:0]     pend_occ_reg, pend_occ_next;

    logic                 m_valid_reg, m_valid_next;
    logic [STATUS_W-1:0]  m_status_reg, m_status_next;
    logic [TAG_W-1:0]     m_tag_reg, m_tag_next;
    logic [TIME_BITS-1:0] m_time_reg, m_time_next;
    logic [OCC_W-1:0]     m_occ_reg, m_occ_next;
    logic                 m_last_reg, m_last_next;

    dotq_op_t             op;
    logic [TIME_BITS-1:0] rd_due, front_due;
    logic [TAG_W-1:0]     front_tag;

    logic [TIME_BITS-1:0] cmp_a, cmp_b;
    logic                 cmp_le;
    logic                 out_free;
    logic                 front_due_now;

    dotq_store u_store (
        .aclk      (aclk),
        .op        (op),
        .rd_due    (rd_due),
        .front_due (front_due),
        .front_tag (front_tag)
    );

    // Shared comparator: operands chosen by the sequencer state
    always_comb begin
        unique case (state_reg)
            S_CHECK: begin
                cmp_a = now_reg;
                cmp_b = due_reg;
            end
            S_SEARCH: begin
                cmp_a = rd_due;
                cmp_b = due_reg;
            end
            default: begin
                cmp_a = front_due;
                cmp_b = now_reg;
            end
        endcase
    end
    assign cmp_le = (cmp_a <= cmp_b);

    assign out_free      = !m_valid_reg || m_ready;
    assign front_due_now = (count_reg != '0) && cmp_le;

    assign s_ready     = (state_reg == S_IDLE);
    assign m_valid     = m_valid_reg;
    assign m_status    = m_status_reg;
    assign m_out_tag   = m_tag_reg;
    assign m_out_time  = m_time_reg;
    assign m_occupancy = m_occ_reg;
    assign m_last      = m_last_reg;

    always_comb begin
        state_next      = state_reg;
        tag_next        = tag_reg;
        due_next        = due_reg;
        now_next        = now_reg;
        idx_next        = idx_reg;
        count_next      = count_reg;
        pend_valid_next = pend_valid_reg;
        pend_tag_next   = pend_tag_reg;
        pend_due_next   = pend_due_reg;
        pend_occ_next   = pend_occ_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_status_next   = m_status_reg;
        m_tag_next      = m_tag_reg;
        m_time_next     = m_time_reg;
        m_occ_next      = m_occ_reg;
        m_last_next     = m_last_reg;

        op     = '0;
        op.pos = idx_reg;
        op.tag = tag_reg;
        op.due = due_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    tag_next        = s_task_tag;
                    due_next        = s_due_time;
                    now_next        = s_current_time;
                    idx_next        = '0;
                    pend_valid_next = 1'b0;
                    state_next      = (s_kind == KIND_TICK) ? S_TICK : S_CHECK;
                end
            end
            S_CHECK: begin
                if (!cmp_le) begin
                    // due time already past
                    if (out_free) begin
                        m_valid_next  = 1'b1;
                        m_status_next = ST_REJ_PAST;
                        m_tag_next    = tag_reg;
                        m_time_next   = due_reg;
                        m_occ_next    = OCC_W'(count_reg);
                        m_last_next   = 1'b1;
                        state_next    = S_IDLE;
                    end
                end else if (count_reg == CNT_W'(QUEUE_DEPTH)) begin
                    if (out_free) begin
                        m_valid_next  = 1'b1;
                        m_status_next = ST_REJ_FULL;
                        m_tag_next    = tag_reg;
                        m_time_next   = due_reg;
                        m_occ_next    = OCC_W'(count_reg);
                        m_last_next   = 1'b1;
                        state_next    = S_IDLE;
                    end
                end else begin
                    state_next = S_SEARCH;
                end
            end
            S_SEARCH: begin
                // walk past entries not later than the new one
                if (CNT_W'(idx_reg) < count_reg && cmp_le) begin
                    idx_next = idx_reg + 1'b1;
                end else if (out_free) begin
                    op.ins        = 1'b1;
                    count_next    = count_reg + 1'b1;
                    m_valid_next  = 1'b1;
                    m_status_next = ST_ADDED;
                    m_tag_next    = tag_reg;
                    m_time_next   = due_reg;
                    m_occ_next    = OCC_W'(count_reg + 1'b1);
                    m_last_next   = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_TICK: begin
                // one popped entry is held back until we know whether it is the last
                if (pend_valid_reg) begin
                    if (out_free) begin
                        m_valid_next  = 1'b1;
                        m_status_next = ST_DISPATCH;
                        m_tag_next    = pend_tag_reg;
                        m_time_next   = pend_due_reg;
                        m_occ_next    = OCC_W'(pend_occ_reg);
                        m_last_next   = !front_due_now;
                        if (front_due_now) begin
                            op.pop        = 1'b1;
                            pend_tag_next = front_tag;
                            pend_due_next = front_due;
                            pend_occ_next = count_reg - 1'b1;
                            count_next    = count_reg - 1'b1;
                        end else begin
                            pend_valid_next = 1'b0;
                            state_next      = S_IDLE;
                        end
                    end
                end else if (front_due_now) begin
                    op.pop          = 1'b1;
                    pend_valid_next = 1'b1;
                    pend_tag_next   = front_tag;
                    pend_due_next   = front_due;
                    pend_occ_next   = count_reg - 1'b1;
                    count_next      = count_reg - 1'b1;
                end else begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
        tag_reg      <= tag_next;
        due_reg      <= due_next;
        now_reg      <= now_next;
        idx_reg      <= idx_next;
        pend_tag_reg <= pend_tag_next;
        pend_due_reg <= pend_due_next;
        pend_occ_reg <= pend_occ_next;
        m_status_reg <= m_status_next;
        m_tag_reg    <= m_tag_next;
        m_time_reg   <= m_time_next;
        m_occ_reg    <= m_occ_next;
        m_last_reg   <= m_last_next;
    end

endmodule

`default_nettype wire
